// File: hw/rtl/lsws_pkg.sv
// ----------------------------------------------------------------------------
// lsws_pkg
// Types, codes and the control store of the search stack sequencer.
// ----------------------------------------------------------------------------
package lsws_pkg;

   // stack depth in words; position fields are sized to count up to it
   localparam int DEPTH    = 16;

   localparam int CMD_W    = 3;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 3;
   localparam int UPC_W    = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_PEEP    = 3'd5;
   localparam logic [CMD_W-1:0] CMD_CHANGE  = 3'd6;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_OVERFLOW  = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_BAD_POS   = 3'd4
   } status_type;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic [POS_W-1:0]         found_position;
      logic                     last;
   } rsp_type;

   // control store addresses, in program order
   typedef enum logic [UPC_W-1:0] {
      U_IDLE    = 5'd0,
      U_PUSH    = 5'd1,
      U_PUSH_W  = 5'd2,
      U_OVF     = 5'd3,
      U_POP     = 5'd4,
      U_POP_E   = 5'd5,
      U_PEEK    = 5'd6,
      U_PEEK_E  = 5'd7,
      U_EMPTY   = 5'd8,
      U_DISP    = 5'd9,
      U_DISP_L  = 5'd10,
      U_SRCH    = 5'd11,
      U_SRCH_L  = 5'd12,
      U_SRCH_R  = 5'd13,
      U_SRCH_F  = 5'd14,
      U_SRCH_NF = 5'd15,
      U_PEEP    = 5'd16,
      U_PEEP_E  = 5'd17,
      U_CHG     = 5'd18,
      U_CHG_W   = 5'd19,
      U_BADPOS  = 5'd20
   } ustep_type;

   typedef enum logic [2:0] {
      C_NONE,
      C_DISPATCH,
      C_FULL,
      C_EMPTY,
      C_BADPOS,
      C_IDX_NZ,
      C_SRCH_MORE,
      C_NOMATCH
   } cond_type;

   typedef enum logic [2:0] {
      RA_TOP,
      RA_POS,
      RA_ZERO,
      RA_IDX_UP,
      RA_IDX_DN
   } rd_sel_type;

   typedef enum logic {
      WA_COUNT,
      WA_POS
   } wr_sel_type;

   typedef enum logic [2:0] {
      IX_HOLD,
      IX_TOP,
      IX_ZERO,
      IX_INC,
      IX_DEC
   } idx_op_type;

   typedef enum logic {
      DS_ZERO,
      DS_RDATA
   } data_sel_type;

   typedef enum logic {
      FS_ZERO,
      FS_IDX
   } fpos_sel_type;

   typedef enum logic {
      LS_ONE,
      LS_IDX_ZERO
   } last_sel_type;

   typedef struct packed {
      logic         latch;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         wr_en;
      wr_sel_type   wr_sel;
      logic         cnt_inc;
      logic         cnt_dec;
      idx_op_type   idx_op;
      logic         emit;
      status_type   status;
      data_sel_type data_sel;
      fpos_sel_type fpos_sel;
      last_sel_type last_sel;
   } dp_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic bad_pos;
      logic idx_zero;
      logic idx_last;
      logic match;
      logic out_free;
   } dp_stat_type;

   // one control word: branch condition and target, end-of-routine flag,
   // gate (datapath acts only when the branch is taken) and datapath controls
   typedef struct packed {
      cond_type   cond;
      ustep_type  target;
      logic       done;
      logic       gate;
      dp_ctl_type dp;
   } uword_type;

   function automatic uword_type ucode_rom(input ustep_type step);
      uword_type w;
      w = '0;
      case (step)
         U_IDLE: begin
            w.cond     = C_DISPATCH;
            w.gate     = 1'b1;
            w.done     = 1'b1;
            w.dp.latch = 1'b1;
         end
         U_PUSH: begin
            w.cond   = C_FULL;
            w.target = U_OVF;
         end
         U_PUSH_W: begin
            w.done       = 1'b1;
            w.dp.wr_en   = 1'b1;
            w.dp.wr_sel  = WA_COUNT;
            w.dp.cnt_inc = 1'b1;
            w.dp.emit    = 1'b1;
            w.dp.status  = ST_OK;
         end
         U_OVF: begin
            w.done      = 1'b1;
            w.dp.emit   = 1'b1;
            w.dp.status = ST_OVERFLOW;
         end
         U_POP, U_PEEK: begin
            w.cond      = C_EMPTY;
            w.target    = U_EMPTY;
            w.dp.rd_en  = 1'b1;
            w.dp.rd_sel = RA_TOP;
         end
         U_POP_E: begin
            w.done        = 1'b1;
            w.dp.cnt_dec  = 1'b1;
            w.dp.emit     = 1'b1;
            w.dp.status   = ST_OK;
            w.dp.data_sel = DS_RDATA;
         end
         U_PEEK_E, U_PEEP_E: begin
            w.done        = 1'b1;
            w.dp.emit     = 1'b1;
            w.dp.status   = ST_OK;
            w.dp.data_sel = DS_RDATA;
         end
         U_EMPTY: begin
            w.done      = 1'b1;
            w.dp.emit   = 1'b1;
            w.dp.status = ST_EMPTY;
         end
         U_DISP: begin
            w.cond      = C_EMPTY;
            w.target    = U_EMPTY;
            w.dp.rd_en  = 1'b1;
            w.dp.rd_sel = RA_TOP;
            w.dp.idx_op = IX_TOP;
         end
         U_DISP_L: begin
            // one word per cycle while the result register is free, top first, next read issued alongside
            w.cond        = C_IDX_NZ;
            w.target      = U_DISP_L;
            w.done        = 1'b1;
            w.dp.rd_en    = 1'b1;
            w.dp.rd_sel   = RA_IDX_DN;
            w.dp.idx_op   = IX_DEC;
            w.dp.emit     = 1'b1;
            w.dp.status   = ST_OK;
            w.dp.data_sel = DS_RDATA;
            w.dp.last_sel = LS_IDX_ZERO;
         end
         U_SRCH: begin
            w.cond      = C_EMPTY;
            w.target    = U_EMPTY;
            w.dp.rd_en  = 1'b1;
            w.dp.rd_sel = RA_ZERO;
            w.dp.idx_op = IX_ZERO;
         end
         U_SRCH_L: begin
            // walk upwards while no match; idx stays on the hit when leaving
            w.cond      = C_SRCH_MORE;
            w.target    = U_SRCH_L;
            w.gate      = 1'b1;
            w.dp.rd_en  = 1'b1;
            w.dp.rd_sel = RA_IDX_UP;
            w.dp.idx_op = IX_INC;
         end
         U_SRCH_R: begin
            w.cond   = C_NOMATCH;
            w.target = U_SRCH_NF;
         end
         U_SRCH_F: begin
            w.done        = 1'b1;
            w.dp.emit     = 1'b1;
            w.dp.status   = ST_OK;
            w.dp.fpos_sel = FS_IDX;
         end
         U_SRCH_NF: begin
            w.done      = 1'b1;
            w.dp.emit   = 1'b1;
            w.dp.status = ST_NOT_FOUND;
         end
         U_PEEP: begin
            w.cond      = C_BADPOS;
            w.target    = U_BADPOS;
            w.dp.rd_en  = 1'b1;
            w.dp.rd_sel = RA_POS;
         end
         U_CHG: begin
            w.cond   = C_BADPOS;
            w.target = U_BADPOS;
         end
         U_CHG_W: begin
            w.done      = 1'b1;
            w.dp.wr_en  = 1'b1;
            w.dp.wr_sel = WA_POS;
            w.dp.emit   = 1'b1;
            w.dp.status = ST_OK;
         end
         U_BADPOS: begin
            w.done      = 1'b1;
            w.dp.emit   = 1'b1;
            w.dp.status = ST_BAD_POS;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/lsws_sequencer.sv
// ----------------------------------------------------------------------------
// lsws_sequencer
// Step counter over the control store, with command dispatch and branches.
// ----------------------------------------------------------------------------
module lsws_sequencer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [lsws_pkg::CMD_W-1:0] req_cmd,
   input  lsws_pkg::dp_stat_type      stat,
   output logic                       req_ready,
   output lsws_pkg::dp_ctl_type       ctl
);
   import lsws_pkg::*;

   ustep_type upc_ff;
   ustep_type upc_in;
   uword_type word;
   logic      cond_true;
   logic      go;
   logic      exec;

   function automatic ustep_type dispatch(input logic [CMD_W-1:0] cmd);
      ustep_type s;
      case (cmd)
         CMD_PUSH:    s = U_PUSH;
         CMD_POP:     s = U_POP;
         CMD_PEEK:    s = U_PEEK;
         CMD_DISPLAY: s = U_DISP;
         CMD_SEARCH:  s = U_SRCH;
         CMD_PEEP:    s = U_PEEP;
         CMD_CHANGE:  s = U_CHG;
         default:     s = U_IDLE;
      endcase
      return s;
   endfunction

   assign word = ucode_rom(upc_ff);

   always_comb begin
      case (word.cond)
         C_NONE:      cond_true = 1'b0;
         C_DISPATCH:  cond_true = req_valid;
         C_FULL:      cond_true = stat.full;
         C_EMPTY:     cond_true = stat.empty;
         C_BADPOS:    cond_true = stat.bad_pos;
         C_IDX_NZ:    cond_true = !stat.idx_zero;
         C_SRCH_MORE: cond_true = !stat.match && !stat.idx_last;
         C_NOMATCH:   cond_true = !stat.match;
         default:     cond_true = 1'b0;
      endcase
   end

   // a step that emits holds while the result register is still occupied
   assign go        = !(word.dp.emit && !stat.out_free);
   assign exec      = go && (!word.gate || cond_true);
   assign ctl       = exec ? word.dp : '0;
   assign req_ready = (upc_ff == U_IDLE) && !reset;

   always_comb begin
      if (!go) begin
         upc_in = upc_ff;
      end else if (cond_true) begin
         upc_in = (word.cond == C_DISPATCH) ? dispatch(req_cmd) : word.target;
      end else if (word.done) begin
         upc_in = U_IDLE;
      end else begin
         upc_in = ustep_type'(UPC_W'(upc_ff) + UPC_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// File: hw/rtl/lsws_datapath.sv
// ----------------------------------------------------------------------------
// lsws_datapath
// Stack memory, count and index registers, compare and result register.
// ----------------------------------------------------------------------------
module lsws_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  lsws_pkg::req_type     req_data,
   input  lsws_pkg::dp_ctl_type  ctl,
   input  logic                  rsp_ready,
   output lsws_pkg::dp_stat_type stat,
   output logic                  rsp_valid,
   output lsws_pkg::rsp_type     rsp_data
);
   import lsws_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int MW = (CW > POS_W) ? CW : POS_W;

   logic signed [DATA_W-1:0] mem [DEPTH];

   req_type                  req_ff;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic [AW-1:0]            idx_ff;
   logic [AW-1:0]            idx_in;
   logic signed [DATA_W-1:0] rdata_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic [MW-1:0]            count_m;
   logic [MW-1:0]            pos_m;
   logic [AW-1:0]            top_addr;
   logic [AW-1:0]            pos_addr;
   logic [AW-1:0]            rd_addr;
   logic [AW-1:0]            wr_addr;

   assign count_m  = MW'(count_ff);
   assign pos_m    = MW'(req_ff.position);
   assign top_addr = AW'(count_ff - CW'(1));
   assign pos_addr = AW'(count_m - pos_m);

   assign stat.full     = (count_ff == CW'(DEPTH));
   assign stat.empty    = (count_ff == '0);
   assign stat.bad_pos  = (pos_m == '0) || (pos_m > count_m);
   assign stat.idx_zero = (idx_ff == '0);
   assign stat.idx_last = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign stat.match    = (rdata_ff == req_ff.value);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (ctl.rd_sel)
         RA_TOP:    rd_addr = top_addr;
         RA_POS:    rd_addr = pos_addr;
         RA_ZERO:   rd_addr = '0;
         RA_IDX_UP: rd_addr = idx_ff + AW'(1);
         RA_IDX_DN: rd_addr = idx_ff - AW'(1);
         default:   rd_addr = '0;
      endcase
   end

   assign wr_addr = (ctl.wr_sel == WA_POS) ? pos_addr : AW'(count_ff);

   always_comb begin
      case (ctl.idx_op)
         IX_HOLD: idx_in = idx_ff;
         IX_TOP:  idx_in = top_addr;
         IX_ZERO: idx_in = '0;
         IX_INC:  idx_in = idx_ff + AW'(1);
         IX_DEC:  idx_in = idx_ff - AW'(1);
         default: idx_in = idx_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= req_ff.value;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         req_ff <= req_data;
      end
      idx_ff <= idx_in;
      if (ctl.emit) begin
         rsp_ff.status         <= ctl.status;
         rsp_ff.data           <= (ctl.data_sel == DS_RDATA) ? rdata_ff : '0;
         rsp_ff.found_position <= (ctl.fpos_sel == FS_IDX) ?
                                  POS_W'(CW'(idx_ff) + CW'(1)) : '0;
         rsp_ff.last           <= (ctl.last_sel == LS_ONE) || stat.idx_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (ctl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hw/rtl/lifo_stack_with_search_core.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search_core
// LIFO stack of signed words with search, display and positional access.
// ----------------------------------------------------------------------------
// Commands arrive on the req_ channel (valid/ready), one at a time; every
// result leaves on the rsp_ channel (valid/ready) from a single result
// register. req_ready is high only while the control sequencer sits in its
// idle step, so a command is taken once the previous one has issued all of
// its results. The sequencer runs one control word per cycle unless an
// emitting step is held by a stalled receiver; the stack lives in a memory
// with one write and one registered read port. Results per command:
//   push, pop, peek, peep, change and all error results: one result each
//   display: one word per cycle while the result register is free, top first
//   search: one result after k compares, k the number of entries compared (up to count)
//   unused command code: no result
// A stalled receiver holds the sequencer on its emitting step; nothing is
// lost or repeated. Reset empties the stack (count to zero) and drops any
// pending result; the memory words are not cleared and hold whatever
// they held.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lsws_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lsws_pkg::rsp_type rsp_data
);
   import lsws_pkg::*;

   dp_ctl_type  ctl;
   dp_stat_type stat;

   lsws_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .stat      (stat),
      .req_ready (req_ready),
      .ctl       (ctl)
   );

   lsws_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // no push into a full stack, no pop from an empty one
   a_no_overfill : assert property (@(posedge clock) disable iff (reset)
      !(ctl.cnt_inc && stat.full))
      else $error("count incremented while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      !(ctl.cnt_dec && stat.empty))
      else $error("count decremented while empty");

   // a waiting result is never overwritten
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten before transfer");

   // positional write only inside 1..count
   a_change_in_range : assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_en && ctl.wr_sel == WA_POS) |-> !stat.bad_pos)
      else $error("positional write outside the stack");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LIFO stack with search and positional access.
// ----------------------------------------------------------------------------
// Commands are queued up front, then handed to the stack by a driver on the
// falling edge. A monitor on the rising edge keeps a shadow stack that is
// stepped on every command transfer and checks each result transfer, field by
// field, against the oldest reply due. The run goes through three handshake
// pressure settings: busy sender with stalling receiver, the reverse, and
// both at full rate.
// ----------------------------------------------------------------------------
module testbench;
   import lsws_pkg::*;

   localparam int STACK_DEPTH = DEPTH;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 150;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // stimulus side
   req_type     cmds_to_send[$];
   logic [31:0] recent_words[$];
   int          plan_depth = 0;
   bit          filling = 1'b1;
   int          req_gap_pct = 20;
   int          rsp_stall_pct = 70;

   // shadow of the stack and the replies it owes
   logic [31:0] shadow_words[STACK_DEPTH];
   int          shadow_fill = 0;
   rsp_type     replies_due[$];
   rsp_type     oldest_reply;

   bit req_fired = 1'b0;
   int cycle_count = 0;
   int error_count = 0;
   int cmd_count = 0;
   int reply_count = 0;
   int full_count = 0;
   int status_count[8];

   lifo_stack_with_search_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(11))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // mostly legal positions, with the edges just outside now and then
   function automatic logic [4:0] pick_position();
      int r;
      r = $urandom_range(9);
      if (plan_depth > 0 && r < 7) return 5'($urandom_range(plan_depth, 1));
      if (r == 7) return 5'(plan_depth + 1);
      if (r == 8) return '0;
      return 5'($urandom_range(31));
   endfunction

   task automatic queue_cmd(input logic [2:0] op, input logic [31:0] word,
                            input logic [4:0] pos);
      req_type item;
      item.cmd = op;
      item.value = word;
      item.position = pos;
      cmds_to_send.push_back(item);
      if (op == CMD_PUSH && plan_depth < STACK_DEPTH) begin
         plan_depth++;
         recent_words.push_back(word);
         if (recent_words.size() > STACK_DEPTH) recent_words.delete(0);
      end else if (op == CMD_POP && plan_depth > 0) begin
         plan_depth--;
      end
   endtask

   // fill and drain sweeps with random reads, searches and edits in between
   task automatic queue_random_cmds(input int n);
      int          pick;
      int          done_cmds;
      logic [2:0]  op;
      logic [31:0] word;
      logic [4:0]  pos;
      done_cmds = 0;
      while (done_cmds < n) begin
         if (plan_depth == 0) filling = 1'b1;
         else if (plan_depth == STACK_DEPTH && $urandom_range(3) == 0) filling = 1'b0;
         else if ($urandom_range(49) == 0) filling = !filling;
         pick = $urandom_range(99);
         word = rand_word();
         pos = 5'($urandom_range(31));
         if (pick < 35) begin
            op = filling ? CMD_PUSH : CMD_POP;
         end else if (pick < 43) begin
            op = filling ? CMD_POP : CMD_PUSH;
         end else if (pick < 50) begin
            op = CMD_PEEK;
         end else if (pick < 59) begin
            op = CMD_DISPLAY;
         end else if (pick < 73) begin
            op = CMD_SEARCH;
            if (recent_words.size() > 0 && $urandom_range(9) < 7)
               word = recent_words[$urandom_range(recent_words.size() - 1)];
         end else if (pick < 96) begin
            op = (pick < 85) ? CMD_PEEP : CMD_CHANGE;
            pos = pick_position();
         end else begin
            op = CMD_UNUSED;
         end
         queue_cmd(op, word, pos);
         if (op != CMD_UNUSED) done_cmds++;
      end
   endtask

   task automatic wait_for_quiet();
      do @(negedge clock);
      while (cmds_to_send.size() != 0 || req_valid || replies_due.size() != 0);
   endtask

   task automatic start_phase(input int gap_pct, input int stall_pct);
      @(posedge clock);
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      queue_random_cmds(ITEMS_PER_PHASE);
   endtask

   // steps the shadow stack by one command and books the replies it causes
   task automatic step_shadow_stack(input req_type r);
      rsp_type res;
      int      i;
      res = '0;
      res.status = ST_OK;
      res.last = 1'b1;
      case (r.cmd)
         CMD_PUSH: begin
            if (shadow_fill == STACK_DEPTH) begin
               res.status = ST_OVERFLOW;
            end else begin
               shadow_words[shadow_fill] = r.value;
               shadow_fill++;
               if (shadow_fill == STACK_DEPTH) full_count++;
            end
         end
         CMD_POP, CMD_PEEK: begin
            if (shadow_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.data = shadow_words[shadow_fill - 1];
               if (r.cmd == CMD_POP) shadow_fill--;
            end
         end
         CMD_DISPLAY: begin
            if (shadow_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               // whole stack, top first, last flag on the bottom word only
               for (i = shadow_fill - 1; i >= 0; i--) begin
                  res.data = shadow_words[i];
                  res.last = (i == 0);
                  replies_due.push_back(res);
                  status_count[res.status]++;
               end
               return;
            end
         end
         CMD_SEARCH: begin
            if (shadow_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.status = ST_NOT_FOUND;
               for (i = 0; i < shadow_fill; i++) begin
                  if (shadow_words[i] == r.value) begin
                     res.status = ST_OK;
                     res.found_position = POS_W'(i + 1);
                     break;
                  end
               end
            end
         end
         CMD_PEEP, CMD_CHANGE: begin
            if (r.position < 1 || r.position > shadow_fill) begin
               res.status = ST_BAD_POS;
            end else if (r.cmd == CMD_PEEP) begin
               res.data = shadow_words[shadow_fill - r.position];
            end else begin
               shadow_words[shadow_fill - r.position] = r.value;
            end
         end
         default: begin
            return;
         end
      endcase
      replies_due.push_back(res);
      status_count[res.status]++;
   endtask

   task automatic compare_field(input string field_name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, field_name, want, got);
         error_count++;
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (cmds_to_send.size() > 0 && $urandom_range(99) >= req_gap_pct) begin
            req_valid <= 1'b1;
            req_data <= cmds_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run timed out", $time);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            cmd_count++;
            step_shadow_stack(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            reply_count++;
            if (replies_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
               error_count++;
            end else begin
               oldest_reply = replies_due.pop_front();
               compare_field("status", 32'(oldest_reply.status), 32'(rsp_data.status));
               compare_field("data", oldest_reply.data, rsp_data.data);
               compare_field("found_position", 32'(oldest_reply.found_position),
                             32'(rsp_data.found_position));
               compare_field("last", 32'(oldest_reply.last), 32'(rsp_data.last));
            end
         end
      end
   end

   initial begin
      // empty stack corners, then a few words with the extreme values
      queue_cmd(CMD_DISPLAY, 32'h0, 5'd0);
      queue_cmd(CMD_POP, 32'h0, 5'd0);
      queue_cmd(CMD_PEEK, 32'h0, 5'd0);
      queue_cmd(CMD_SEARCH, 32'hffff_ffff, 5'd0);
      queue_cmd(CMD_PEEP, 32'h0, 5'd1);
      queue_cmd(CMD_CHANGE, 32'h1234_5678, 5'd0);
      queue_cmd(CMD_UNUSED, 32'hffff_ffff, 5'd31);
      queue_cmd(CMD_PUSH, 32'h7fff_ffff, 5'd31);
      queue_cmd(CMD_PUSH, 32'h8000_0000, 5'd0);
      queue_cmd(CMD_PUSH, 32'h0000_0000, 5'd0);
      queue_cmd(CMD_PUSH, 32'hffff_ffff, 5'd0);
      queue_cmd(CMD_PUSH, 32'h8000_0000, 5'd0);
      queue_cmd(CMD_PEEK, 32'h0, 5'd0);
      queue_cmd(CMD_SEARCH, 32'h8000_0000, 5'd0);
      queue_cmd(CMD_SEARCH, 32'h0001_2345, 5'd0);
      queue_cmd(CMD_PEEP, 32'h0, 5'd1);
      queue_cmd(CMD_PEEP, 32'h0, 5'd5);
      queue_cmd(CMD_PEEP, 32'h0, 5'd6);
      queue_cmd(CMD_PEEP, 32'h0, 5'd31);
      queue_cmd(CMD_CHANGE, 32'h1357_9bdf, 5'd5);
      queue_cmd(CMD_CHANGE, 32'h2468_ace0, 5'd0);
      queue_cmd(CMD_SEARCH, 32'h1357_9bdf, 5'd0);
      queue_cmd(CMD_DISPLAY, 32'h0, 5'd0);
      queue_cmd(CMD_POP, 32'h0, 5'd0);
      queue_random_cmds(ITEMS_PER_PHASE);

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      wait_for_quiet();
      start_phase(70, 20);
      wait_for_quiet();
      start_phase(0, 0);
      wait_for_quiet();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("%0d commands and %0d results checked under three pressure settings",
               cmd_count, reply_count);
      $display("stack filled %0d times; %0d overflow, %0d empty, %0d not found, %0d bad position",
               full_count, status_count[ST_OVERFLOW], status_count[ST_EMPTY],
               status_count[ST_NOT_FOUND], status_count[ST_BAD_POS]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
